// File: design/postfix_stack_evaluator_top_macros.svh
// Assertion macros shared by the postfix stack evaluator RTL.
`ifndef POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under a synchronous active-high reset
`define PSE_ASSERT(lbl, clk_sig, rst_sig, cond, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |-> (prop)) \
    else $error("pse assertion failed");

// Next-cycle implication under a synchronous active-high reset
`define PSE_ASSERT_NXT(lbl, clk_sig, rst_sig, cond, prop) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond) |=> (prop)) \
    else $error("pse assertion failed");

`else

`define PSE_ASSERT(lbl, clk_sig, rst_sig, cond, prop)
`define PSE_ASSERT_NXT(lbl, clk_sig, rst_sig, cond, prop)

`endif

`endif

// File: design/pse_pkg.sv
// Types and codes shared by the postfix stack evaluator modules.
`default_nettype none

package pse_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 5;

  // Token kinds
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_OP   = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;

  // Operator codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
  localparam logic [1:0] STAT_DIV_ZERO  = 2'd3;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_READ_B,
    SEQ_LATCH_B,
    SEQ_ALU,
    SEQ_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_DIV,
    ALU_FIX
  } alu_state_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

// File: design/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/pse_alu.sv
// Shared arithmetic unit: registered add/sub/mul, 32-step restoring divider.
`default_nettype none

module pse_alu (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pse_pkg::alu_req_t          req,
  input  wire logic [pse_pkg::DATA_W-1:0] opnd_a,   // top of stack
  input  wire logic [pse_pkg::DATA_W-1:0] opnd_b,   // entry below top
  output pse_pkg::alu_rsp_t               rsp,
  output logic      [pse_pkg::DATA_W-1:0] result
);

`include "postfix_stack_evaluator_top_macros.svh"

  pse_pkg::alu_state_t alu_state, alu_state_next;

  logic [pse_pkg::CNT_W-1:0]  count;
  logic [pse_pkg::DATA_W-1:0] rem;
  logic [pse_pkg::DATA_W-1:0] quot;
  logic [pse_pkg::DATA_W-1:0] den;
  logic                       neg;
  logic                       done;
  logic                       div_zero;

  logic [pse_pkg::DATA_W:0]   shifted;
  logic [pse_pkg::DATA_W:0]   diff;
  logic                       fits;
  logic [pse_pkg::DATA_W-1:0] mag_a;
  logic [pse_pkg::DATA_W-1:0] mag_b;

  assign rsp.done     = done;
  assign rsp.div_zero = div_zero;

  // Operand magnitudes for the divider
  assign mag_a = opnd_a[pse_pkg::DATA_W-1] ? ('0 - opnd_a) : opnd_a;
  assign mag_b = opnd_b[pse_pkg::DATA_W-1] ? ('0 - opnd_b) : opnd_b;

  // One restoring step: shift in next dividend bit, trial subtract
  assign shifted = {rem, quot[pse_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, den};
  assign fits    = ~diff[pse_pkg::DATA_W];

  // Next state
  always_comb begin
    alu_state_next = alu_state;
    case (alu_state)
      pse_pkg::ALU_IDLE: begin
        if (req.start && (req.op == pse_pkg::OP_DIV) && (opnd_b != '0)) begin
          alu_state_next = pse_pkg::ALU_DIV;
        end
      end
      pse_pkg::ALU_DIV: begin
        if (count == '0) begin
          alu_state_next = pse_pkg::ALU_FIX;
        end
      end
      pse_pkg::ALU_FIX: alu_state_next = pse_pkg::ALU_IDLE;
      default:          alu_state_next = pse_pkg::ALU_IDLE;
    endcase
  end

  // State register and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      alu_state <= pse_pkg::ALU_IDLE;
      done      <= 1'b0;
    end else begin
      alu_state <= alu_state_next;
      done      <= 1'b0;
      if (alu_state == pse_pkg::ALU_IDLE && req.start) begin
        done <= (req.op != pse_pkg::OP_DIV) || (opnd_b == '0);
      end else if (alu_state == pse_pkg::ALU_FIX) begin
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (alu_state)
      pse_pkg::ALU_IDLE: begin
        if (req.start) begin
          div_zero <= 1'b0;
          case (req.op)
            pse_pkg::OP_ADD: result <= opnd_a + opnd_b;
            pse_pkg::OP_SUB: result <= opnd_a - opnd_b;
            pse_pkg::OP_MUL: result <= opnd_a * opnd_b;
            default: begin
              if (opnd_b == '0) begin
                result   <= '0;
                div_zero <= 1'b1;
              end else begin
                rem   <= '0;
                quot  <= mag_a;
                den   <= mag_b;
                neg   <= opnd_a[pse_pkg::DATA_W-1] ^ opnd_b[pse_pkg::DATA_W-1];
                count <= pse_pkg::CNT_W'(pse_pkg::DIV_STEPS - 1);
              end
            end
          endcase
        end
      end
      pse_pkg::ALU_DIV: begin
        rem   <= fits ? diff[pse_pkg::DATA_W-1:0] : shifted[pse_pkg::DATA_W-1:0];
        quot  <= {quot[pse_pkg::DATA_W-2:0], fits};
        count <= count - 1'b1;
      end
      pse_pkg::ALU_FIX: begin
        result <= neg ? ('0 - quot) : quot;
      end
      default: ;
    endcase
  end

  `PSE_ASSERT(a_start_when_idle, clk, rst, req.start, alu_state == pse_pkg::ALU_IDLE)
  `PSE_ASSERT_NXT(a_fix_gives_done, clk, rst, alu_state == pse_pkg::ALU_FIX, done)
  `PSE_ASSERT(a_div_zero_done, clk, rst, div_zero && !done, alu_state == pse_pkg::ALU_IDLE)

endmodule

`default_nettype wire

// File: design/postfix_stack_evaluator_top.sv
// Postfix integer stack evaluator: token stream in, one status/result per token out.
//
//  channel | dir | tdata           | tuser                           | tlast
//  s_*     | in  | number[31:0]    | action[1:0], operator_code[3:2] | -
//  m_*     | out | result_value    | status[1:0]                     | expression_done
//
// Push, end and rejected tokens: idle, then emit, then the output register.
// Add, subtract, multiply: read B, latch B, ALU, emit (two reads, ALU, write).
// Divide: the sequencer waits in the ALU state for the 32-step shared divider, except on a zero divisor.
// One token at a time; s_tready is high only while the sequencer is idle.
// A stalled output holds its register; the next token is taken meanwhile.
// rst clears the stack fill and last result; stack RAM contents are kept.
`default_nettype none

module postfix_stack_evaluator_top #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // number[31:0]
  input  wire logic [3:0]  s_tuser,   // action[1:0], operator_code[3:2]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // result_value[31:0]
  output logic      [1:0]  m_tuser,   // status[1:0]
  output logic             m_tlast    // expression_done
);

`include "postfix_stack_evaluator_top_macros.svh"

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(STACK_DEPTH);
  localparam logic [FILL_W-1:0] FILL_TWO  = FILL_W'(2);

  pse_pkg::seq_state_t state, state_next;

  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          fill_m1;
  logic [FILL_W-1:0]          fill_m2;
  logic [pse_pkg::DATA_W-1:0] last_result;
  logic [pse_pkg::DATA_W-1:0] opnd_a;
  logic [1:0]                 op_code;
  logic [1:0]                 res_status;
  logic                       res_done;
  logic [pse_pkg::DATA_W-1:0] res_value;

  logic       accept;
  logic [1:0] in_action;
  logic [1:0] in_op;
  logic       out_free;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [pse_pkg::DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [pse_pkg::DATA_W-1:0] ram_rdata;

  pse_pkg::alu_req_t          alu_req;
  pse_pkg::alu_rsp_t          alu_rsp;
  logic [pse_pkg::DATA_W-1:0] alu_result;

  assign in_action = s_tuser[1:0];
  assign in_op     = s_tuser[3:2];
  assign s_tready  = (state == pse_pkg::SEQ_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;
  assign fill_m1   = fill - 1'b1;
  assign fill_m2   = fill - FILL_TWO;

  // Stack memory
  pse_ram #(
    .WIDTH (pse_pkg::DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared arithmetic unit
  pse_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opnd_a (opnd_a),
    .opnd_b (ram_rdata),
    .rsp    (alu_rsp),
    .result (alu_result)
  );

  // Stack ports: top is read while idle, the entry below on the next cycle
  always_comb begin
    ram_raddr = (state == pse_pkg::SEQ_IDLE) ? fill_m1[ADDR_W-1:0] : fill_m2[ADDR_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = fill[ADDR_W-1:0];
    ram_wdata = s_tdata;
    if (accept && (in_action == pse_pkg::ACT_PUSH) && (fill != FILL_FULL)) begin
      ram_we = 1'b1;
    end else if ((state == pse_pkg::SEQ_ALU) && alu_rsp.done) begin
      ram_we    = 1'b1;
      ram_waddr = fill_m2[ADDR_W-1:0];
      ram_wdata = alu_result;
    end
  end

  assign alu_req.start = (state == pse_pkg::SEQ_LATCH_B);
  assign alu_req.op    = op_code;

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      pse_pkg::SEQ_IDLE: begin
        if (accept) begin
          if ((in_action == pse_pkg::ACT_OP) && (fill >= FILL_TWO)) begin
            state_next = pse_pkg::SEQ_READ_B;
          end else begin
            state_next = pse_pkg::SEQ_EMIT;
          end
        end
      end
      pse_pkg::SEQ_READ_B:  state_next = pse_pkg::SEQ_LATCH_B;
      pse_pkg::SEQ_LATCH_B: state_next = pse_pkg::SEQ_ALU;
      pse_pkg::SEQ_ALU: begin
        if (alu_rsp.done) begin
          state_next = pse_pkg::SEQ_EMIT;
        end
      end
      pse_pkg::SEQ_EMIT: begin
        if (out_free) begin
          state_next = pse_pkg::SEQ_IDLE;
        end
      end
      default: state_next = pse_pkg::SEQ_IDLE;
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stack fill and last operator result
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      last_result <= '0;
    end else if (accept) begin
      case (in_action)
        pse_pkg::ACT_PUSH: begin
          if (fill != FILL_FULL) begin
            fill <= fill + 1'b1;
          end
        end
        pse_pkg::ACT_END: begin
          fill        <= '0;
          last_result <= '0;
        end
        default: ;
      endcase
    end else if ((state == pse_pkg::SEQ_ALU) && alu_rsp.done) begin
      fill        <= fill_m1;
      last_result <= alu_result;
    end
  end

  // Pending result fields and operand capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_code    <= in_op;
      res_done   <= 1'b0;
      res_status <= pse_pkg::STAT_OK;
      res_value  <= last_result;
      case (in_action)
        pse_pkg::ACT_PUSH: begin
          if (fill == FILL_FULL) begin
            res_status <= pse_pkg::STAT_OVERFLOW;
          end
        end
        pse_pkg::ACT_OP: begin
          if (fill < FILL_TWO) begin
            res_status <= pse_pkg::STAT_UNDERFLOW;
          end
        end
        pse_pkg::ACT_END: res_done <= 1'b1;
        default: ;
      endcase
    end
    if (state == pse_pkg::SEQ_READ_B) begin
      opnd_a <= ram_rdata;
    end
    if ((state == pse_pkg::SEQ_ALU) && alu_rsp.done) begin
      res_value  <= alu_result;
      res_status <= alu_rsp.div_zero ? pse_pkg::STAT_DIV_ZERO : pse_pkg::STAT_OK;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == pse_pkg::SEQ_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if ((state == pse_pkg::SEQ_EMIT) && out_free) begin
      m_tdata <= res_value;
      m_tuser <= res_status;
      m_tlast <= res_done;
    end
  end

  `PSE_ASSERT(a_fill_bound, clk, rst, 1'b1, fill <= FILL_FULL)
  `PSE_ASSERT_NXT(a_end_clears, clk, rst, accept && (in_action == pse_pkg::ACT_END), (fill == '0) && (last_result == '0))
  `PSE_ASSERT(a_alu_done_waited, clk, rst, alu_rsp.done, state == pse_pkg::SEQ_ALU)
  `PSE_ASSERT_NXT(a_push_grows, clk, rst, accept && (in_action == pse_pkg::ACT_PUSH) && (fill != FILL_FULL), fill == $past(fill) + 1'b1)

endmodule

`default_nettype wire
